>>> rtl/core/xrl_pkg.sv
// Shared types and constants of the XOR rectangle/line draw engine.
// Used by the channel interfaces, the clip unit and the top level.
package xrl_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ExtW   = 16;
  localparam int unsigned WdatW  = 8;
  localparam int unsigned RdatW  = 8;
  localparam int unsigned RegW   = 7;   // active size registers, also coordinate width
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned SegW   = 20;  // signed segment math, holds pos +/- extent sums

  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned DefPixelBits = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_HLINE = 3'd0,
    CMD_VLINE = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_WRPIX = 3'd3,
    CMD_RDPIX = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEG_SEL,
    ST_SEG_CLIP,
    ST_PX_RD,
    ST_PX_WR,
    ST_PIX,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  // One clipped segment: draw flag, first and one-past-last coordinate, fixed coordinate.
  typedef struct packed {
    logic            draw;
    logic [RegW-1:0] start;
    logic [RegW-1:0] stop;
    logic [RegW-1:0] fix;
  } clip_res_t;

endpackage

>>> rtl/core/xrl_if.sv
// Valid/ready channel interfaces for command and response beats.
// Depends on xrl_pkg for field widths.
interface xrl_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [xrl_pkg::CmdW-1:0]            cmd;
  logic signed [xrl_pkg::PosW-1:0]     pos_x;
  logic signed [xrl_pkg::PosW-1:0]     pos_y;
  logic [xrl_pkg::ExtW-1:0]            extent_a;
  logic [xrl_pkg::ExtW-1:0]            extent_b;
  logic [xrl_pkg::WdatW-1:0]           write_data;

  modport source (output valid, cmd, pos_x, pos_y, extent_a, extent_b, write_data,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, extent_a, extent_b, write_data,
                  output ready);
endinterface

interface xrl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [xrl_pkg::RdatW-1:0]    read_data;
  logic                         outside;

  modport source (output valid, read_data, outside, input ready);
  modport sink   (input valid, read_data, outside, output ready);
endinterface

>>> rtl/core/xrl_clip.sv
// Segment clip unit: clamps one line segment to the active area.
// Depends on xrl_pkg (clip_res_t, widths).
module xrl_clip (
  input  logic signed [xrl_pkg::SegW-1:0] along_i,   // start along the line
  input  logic signed [xrl_pkg::SegW-1:0] fix_i,     // row of an h-line, column of a v-line
  input  logic signed [xrl_pkg::SegW-1:0] len_i,
  input  logic [xrl_pkg::RegW-1:0]        lim_along_i,
  input  logic [xrl_pkg::RegW-1:0]        lim_fix_i,
  output xrl_pkg::clip_res_t              res_o
);

  logic signed [xrl_pkg::SegW-1:0] lim_a_s;
  logic signed [xrl_pkg::SegW-1:0] lim_f_s;
  logic signed [xrl_pkg::SegW-1:0] start_s;
  logic signed [xrl_pkg::SegW-1:0] end_s;
  logic signed [xrl_pkg::SegW-1:0] end_c;

  always_comb begin
    lim_a_s = xrl_pkg::SegW'(lim_along_i);
    lim_f_s = xrl_pkg::SegW'(lim_fix_i);
    start_s = (along_i < 0) ? '0 : along_i;
    end_s   = along_i + len_i;
    end_c   = (end_s > lim_a_s) ? lim_a_s : end_s;
    // A line ending at or before coordinate 0 gives end_c <= start_s and draws nothing.
    res_o.draw  = (len_i > 0) && (fix_i >= 0) && (fix_i < lim_f_s) && (start_s < end_c);
    res_o.start = xrl_pkg::RegW'(start_s);
    res_o.stop  = xrl_pkg::RegW'(end_c);
    res_o.fix   = xrl_pkg::RegW'(fix_i);
  end

endmodule

>>> rtl/core/xrl_fstore.sv
// Frame store: single-port pixel memory with registered read data.
// No dependencies; contents undefined until written.
module xrl_fstore #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/xor_rect_line_draw_engine.sv
// Top level of the XOR rectangle/line draw engine: sequencer, config registers,
// response register. Depends on xrl_pkg, xrl_if, xrl_clip and xrl_fstore.
//
//   channel  | dir | fields
//   ---------+-----+---------------------------------------------------------
//   cmd_if   | in  | cmd, pos_x, pos_y, extent_a, extent_b, write_data
//   rsp_if   | out | read_data, outside
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (no handshake)
//
// Steps: a line is set up through decode, segment select and clip, then each visible
// pixel is read and written back inverted through the one frame store port; a
// rectangle runs four such segments; pixel write/read go through ST_PIX (a read also
// through ST_RD_WAIT). ST_DONE moves the result into the response register. cmd_if.ready is high only while idle.
// Reset sets active size to the store size; the frame store is not cleared.
// A stalled response holds in its register; the next command is taken meanwhile.
module xor_rect_line_draw_engine #(
  parameter int unsigned MAX_WIDTH  = xrl_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = xrl_pkg::DefMaxHeight,
  parameter int unsigned PIXEL_BITS = xrl_pkg::DefPixelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xrl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [xrl_pkg::RegW-1:0]      cfg_wdata_i,
  xrl_cmd_if.sink                       cmd_if,
  xrl_rsp_if.source                     rsp_if
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RegW  = xrl_pkg::RegW;
  localparam int unsigned SegW  = xrl_pkg::SegW;

  // Configuration
  logic [RegW-1:0] aw_q, ah_q;
  logic [RegW-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= RegW'(MAX_WIDTH);
      ah_q <= RegW'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (xrl_pkg::reg_idx_e'(cfg_idx_i))
        xrl_pkg::REG_ACTIVE_WIDTH:  aw_q <= cfg_wdata_i;
        xrl_pkg::REG_ACTIVE_HEIGHT: ah_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (int'(aw_q) < MAX_WIDTH)  ? aw_q : RegW'(MAX_WIDTH);
  assign h_eff = (int'(ah_q) < MAX_HEIGHT) ? ah_q : RegW'(MAX_HEIGHT);

  // Sequencer state
  xrl_pkg::state_e state_q, state_d;

  logic [xrl_pkg::CmdW-1:0]         cmd_q;
  logic signed [xrl_pkg::PosW-1:0]  px_q, py_q;
  logic [xrl_pkg::ExtW-1:0]         ea_q, eb_q;
  logic [PIXEL_BITS-1:0]            wd_q;
  logic                             cmd_ld;

  logic [1:0]                       seg_idx_q, seg_idx_d;
  logic [1:0]                       seg_last_q, seg_last_d;
  logic                             seg_vert_q, seg_vert_d;
  logic signed [SegW-1:0]           seg_a_q, seg_a_d;
  logic signed [SegW-1:0]           seg_f_q, seg_f_d;
  logic signed [SegW-1:0]           seg_len_q, seg_len_d;

  logic [RegW-1:0]                  cur_q, cur_d;
  logic [RegW-1:0]                  stop_q, stop_d;
  logic [RegW-1:0]                  fix_q, fix_d;

  logic [xrl_pkg::RdatW-1:0]        res_rd_q, res_rd_d;
  logic                             res_out_q, res_out_d;

  logic                             rsp_valid_q, rsp_valid_d;
  logic [xrl_pkg::RdatW-1:0]        rsp_rd_q, rsp_rd_d;
  logic                             rsp_out_q, rsp_out_d;

  // Shared clip unit
  xrl_pkg::clip_res_t clip_res;

  xrl_clip u_clip (
    .along_i     (seg_a_q),
    .fix_i       (seg_f_q),
    .len_i       (seg_len_q),
    .lim_along_i (seg_vert_q ? h_eff : w_eff),
    .lim_fix_i   (seg_vert_q ? w_eff : h_eff),
    .res_o       (clip_res)
  );

  // Frame store
  logic                  mem_we;
  logic [AddrW-1:0]      mem_addr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic [PIXEL_BITS-1:0] mem_rdata;
  logic [RegW-1:0]       addr_row, addr_col;

  xrl_fstore #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (PIXEL_BITS)
  ) u_fstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    if (state_q == xrl_pkg::ST_PIX) begin
      addr_row = RegW'(py_q);
      addr_col = RegW'(px_q);
    end else if (seg_vert_q) begin
      addr_row = cur_q;
      addr_col = fix_q;
    end else begin
      addr_row = fix_q;
      addr_col = cur_q;
    end
  end

  assign mem_addr = AddrW'(AddrW'(addr_row) * AddrW'(MAX_WIDTH)) + AddrW'(addr_col);

  // Command fields and active size widened to SegW (positions sign-extended, extents and size zero-extended)
  logic signed [SegW-1:0] x_s, y_s, ea_s, eb_s, w_s, h_s;
  logic                   pix_outside;

  assign x_s  = SegW'(px_q);
  assign y_s  = SegW'(py_q);
  assign ea_s = SegW'(ea_q);
  assign eb_s = SegW'(eb_q);
  assign w_s  = SegW'(w_eff);
  assign h_s  = SegW'(h_eff);
  assign pix_outside = (x_s < 0) || (y_s < 0) || (x_s >= w_s) || (y_s >= h_s);

  assign cmd_if.ready = (state_q == xrl_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_ld      = 1'b0;
    seg_idx_d   = seg_idx_q;
    seg_last_d  = seg_last_q;
    seg_vert_d  = seg_vert_q;
    seg_a_d     = seg_a_q;
    seg_f_d     = seg_f_q;
    seg_len_d   = seg_len_q;
    cur_d       = cur_q;
    stop_d      = stop_q;
    fix_d       = fix_q;
    res_rd_d    = res_rd_q;
    res_out_d   = res_out_q;
    rsp_valid_d = rsp_valid_q && !rsp_if.ready;
    rsp_rd_d    = rsp_rd_q;
    rsp_out_d   = rsp_out_q;
    mem_we      = 1'b0;
    mem_wdata   = ~mem_rdata;

    case (state_q)
      xrl_pkg::ST_IDLE: begin
        if (cmd_if.valid) begin
          cmd_ld  = 1'b1;
          state_d = xrl_pkg::ST_DECODE;
        end
      end

      xrl_pkg::ST_DECODE: begin
        res_rd_d   = '0;
        res_out_d  = 1'b0;
        seg_idx_d  = 2'd0;
        seg_last_d = 2'd0;
        case (xrl_pkg::cmd_e'(cmd_q))
          xrl_pkg::CMD_HLINE, xrl_pkg::CMD_VLINE: state_d = xrl_pkg::ST_SEG_SEL;
          xrl_pkg::CMD_RECT: begin
            seg_last_d = 2'd3;
            // Zero width or height draws nothing
            state_d = ((ea_q == '0) || (eb_q == '0)) ? xrl_pkg::ST_DONE
                                                   : xrl_pkg::ST_SEG_SEL;
          end
          xrl_pkg::CMD_WRPIX, xrl_pkg::CMD_RDPIX: state_d = xrl_pkg::ST_PIX;
          default: state_d = xrl_pkg::ST_DONE;
        endcase
      end

      xrl_pkg::ST_SEG_SEL: begin
        // Rectangle order: top row, bottom row, left column, right column
        case (seg_idx_q)
          2'd0: begin
            seg_vert_d = (xrl_pkg::cmd_e'(cmd_q) == xrl_pkg::CMD_VLINE);
            seg_a_d    = seg_vert_d ? y_s : x_s;
            seg_f_d    = seg_vert_d ? x_s : y_s;
            seg_len_d  = ea_s;
          end
          2'd1: begin
            seg_vert_d = 1'b0;
            seg_a_d    = x_s;
            seg_f_d    = y_s + eb_s - SegW'(1);
            seg_len_d  = ea_s;
          end
          2'd2: begin
            seg_vert_d = 1'b1;
            seg_a_d    = y_s + SegW'(1);
            seg_f_d    = x_s;
            seg_len_d  = eb_s - SegW'(1);
          end
          default: begin
            seg_vert_d = 1'b1;
            seg_a_d    = y_s + SegW'(1);
            seg_f_d    = x_s + ea_s - SegW'(1);
            seg_len_d  = eb_s - SegW'(1);
          end
        endcase
        state_d = xrl_pkg::ST_SEG_CLIP;
      end

      xrl_pkg::ST_SEG_CLIP: begin
        cur_d  = clip_res.start;
        stop_d = clip_res.stop;
        fix_d  = clip_res.fix;
        if (clip_res.draw) begin
          state_d = xrl_pkg::ST_PX_RD;
        end else if (seg_idx_q == seg_last_q) begin
          state_d = xrl_pkg::ST_DONE;
        end else begin
          seg_idx_d = seg_idx_q + 2'd1;
          state_d   = xrl_pkg::ST_SEG_SEL;
        end
      end

      xrl_pkg::ST_PX_RD: begin
        state_d = xrl_pkg::ST_PX_WR;
      end

      xrl_pkg::ST_PX_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ~mem_rdata;
        cur_d     = cur_q + RegW'(1);
        if (cur_d != stop_q) begin
          state_d = xrl_pkg::ST_PX_RD;
        end else if (seg_idx_q == seg_last_q) begin
          state_d = xrl_pkg::ST_DONE;
        end else begin
          seg_idx_d = seg_idx_q + 2'd1;
          state_d   = xrl_pkg::ST_SEG_SEL;
        end
      end

      xrl_pkg::ST_PIX: begin
        if (pix_outside) begin
          res_out_d = 1'b1;
          state_d   = xrl_pkg::ST_DONE;
        end else if (xrl_pkg::cmd_e'(cmd_q) == xrl_pkg::CMD_WRPIX) begin
          mem_we    = 1'b1;
          mem_wdata = wd_q;
          state_d   = xrl_pkg::ST_DONE;
        end else begin
          state_d = xrl_pkg::ST_RD_WAIT;
        end
      end

      xrl_pkg::ST_RD_WAIT: begin
        res_rd_d = xrl_pkg::RdatW'(mem_rdata);
        state_d  = xrl_pkg::ST_DONE;
      end

      xrl_pkg::ST_DONE: begin
        // Hold until the response register is free
        if (!rsp_valid_q || rsp_if.ready) begin
          rsp_valid_d = 1'b1;
          rsp_rd_d    = res_rd_q;
          rsp_out_d   = res_out_q;
          state_d     = xrl_pkg::ST_IDLE;
        end
      end

      default: state_d = xrl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xrl_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
      seg_idx_q   <= '0;
      seg_last_q  <= '0;
      seg_vert_q  <= 1'b0;
      cur_q       <= '0;
      stop_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      seg_idx_q   <= seg_idx_d;
      seg_last_q  <= seg_last_d;
      seg_vert_q  <= seg_vert_d;
      cur_q       <= cur_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ld) begin
      cmd_q <= cmd_if.cmd;
      px_q  <= cmd_if.pos_x;
      py_q  <= cmd_if.pos_y;
      ea_q  <= cmd_if.extent_a;
      eb_q  <= cmd_if.extent_b;
      wd_q  <= PIXEL_BITS'(cmd_if.write_data);
    end
    seg_a_q   <= seg_a_d;
    seg_f_q   <= seg_f_d;
    seg_len_q <= seg_len_d;
    fix_q     <= fix_d;
    res_rd_q  <= res_rd_d;
    res_out_q <= res_out_d;
    rsp_rd_q  <= rsp_rd_d;
    rsp_out_q <= rsp_out_d;
  end

  assign rsp_if.valid     = rsp_valid_q;
  assign rsp_if.read_data = rsp_rd_q;
  assign rsp_if.outside   = rsp_out_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_if.valid && cmd_if.ready |=> state_q == xrl_pkg::ST_DECODE)
    else $error("command accepted but sequencer did not start");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xrl_pkg::ST_PX_RD || state_q == xrl_pkg::ST_PX_WR) |-> cur_q < stop_q)
    else $error("pixel walk ran past segment end");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == xrl_pkg::ST_DONE)
    else $error("response raised outside of completion");

  a_walk_inside_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == xrl_pkg::ST_PX_WR |->
      (seg_vert_q ? (cur_q < h_eff && fix_q < w_eff) : (cur_q < w_eff && fix_q < h_eff)))
    else $error("inverted pixel outside the active area");

endmodule
